/* rtl/core/ifp_pkg.sv */
// Package for the IPv4 fragment planner: word types, microcode control word,
// step and status codes, and the header checksum fold.
// No dependencies; every other file in rtl/core uses it.
`default_nettype none

package ifp_pkg;

  localparam int unsigned STEP_W = 2;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE  = 2'd0;
  localparam step_t STEP_TEST  = 2'd1;
  localparam step_t STEP_CHUNK = 2'd2;
  localparam step_t STEP_EMIT  = 2'd3;

  localparam logic [15:0] MTU_FLOOR = 16'd1280;
  localparam logic [15:0] MTU_RESET = 16'd1500;

  localparam int unsigned RSV_BIT = 15;
  localparam int unsigned DF_BIT  = 14;
  localparam int unsigned MF_BIT  = 13;
  localparam int unsigned OFF_W   = 13;

  localparam logic [1:0] STATUS_FRAG  = 2'd0;
  localparam logic [1:0] STATUS_DF    = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_INIT  = 2'd1,
    OP_CHUNK = 2'd2,
    OP_EMIT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_NO_INPUT = 3'd1,
    C_OUT_FULL = 3'd2,
    C_SPECIAL  = 3'd3,
    C_NOT_LAST = 3'd4
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t wait_sel;
    cond_t br_sel;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic out_full;
    logic special;
    logic last;
  } flags_t;

  typedef struct packed {
    logic [5:0]  header_len;
    logic [15:0] total_len;
    logic [15:0] offset_flags;
    logic [15:0] partial_sum;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] frag_offset_flags;
    logic [15:0] frag_total_len;
    logic [15:0] frag_checksum;
    logic [15:0] data_start;
    logic [15:0] data_len;
    logic        last;
  } out_word_t;

  function automatic logic [15:0] csum_fold(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] c);
    logic [17:0] s;
    logic [16:0] t;
    logic [16:0] u;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    t = {1'b0, s[15:0]} + {15'd0, s[17:16]};
    u = {1'b0, t[15:0]} + {16'd0, t[16]};
    return ~u[15:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ifp_ucode_rom.sv */
// Microcode store of the fragment planner: one control word per step.
// Depends on ifp_pkg.
`default_nettype none

module ifp_ucode_rom (
  input  wire ifp_pkg::step_t      step,
  output ifp_pkg::ctrl_word_t      ctrl
);

  always_comb begin
    case (step)
      ifp_pkg::STEP_IDLE: begin
        ctrl = '{op: ifp_pkg::OP_LOAD, wait_sel: ifp_pkg::C_NO_INPUT,
                 br_sel: ifp_pkg::C_NEVER, target: ifp_pkg::STEP_IDLE};
      end
      ifp_pkg::STEP_TEST: begin
        ctrl = '{op: ifp_pkg::OP_INIT, wait_sel: ifp_pkg::C_NEVER,
                 br_sel: ifp_pkg::C_SPECIAL, target: ifp_pkg::STEP_EMIT};
      end
      ifp_pkg::STEP_CHUNK: begin
        ctrl = '{op: ifp_pkg::OP_CHUNK, wait_sel: ifp_pkg::C_NEVER,
                 br_sel: ifp_pkg::C_NEVER, target: ifp_pkg::STEP_IDLE};
      end
      ifp_pkg::STEP_EMIT: begin
        ctrl = '{op: ifp_pkg::OP_EMIT, wait_sel: ifp_pkg::C_OUT_FULL,
                 br_sel: ifp_pkg::C_NOT_LAST, target: ifp_pkg::STEP_CHUNK};
      end
      default: begin
        ctrl = '{op: ifp_pkg::OP_LOAD, wait_sel: ifp_pkg::C_NO_INPUT,
                 br_sel: ifp_pkg::C_NEVER, target: ifp_pkg::STEP_IDLE};
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/ifp_sequencer.sv */
// Step counter of the fragment planner: holds, branches or advances by the
// control word and the datapath flags.
// Depends on ifp_pkg.
`default_nettype none

module ifp_sequencer (
  input  wire                      clk,
  input  wire                      rst,
  input  wire ifp_pkg::ctrl_word_t ctrl,
  input  wire ifp_pkg::flags_t     flags,
  output ifp_pkg::step_t           step
);

  ifp_pkg::step_t step_next;
  logic           wait_hit;
  logic           br_hit;

  function automatic logic cond_hit(input ifp_pkg::cond_t c, input ifp_pkg::flags_t f);
    logic r;
    case (c)
      ifp_pkg::C_NEVER:    r = 1'b0;
      ifp_pkg::C_NO_INPUT: r = !f.in_valid;
      ifp_pkg::C_OUT_FULL: r = f.out_full;
      ifp_pkg::C_SPECIAL:  r = f.special;
      ifp_pkg::C_NOT_LAST: r = !f.last;
      default:             r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    wait_hit = cond_hit(ctrl.wait_sel, flags);
    br_hit   = cond_hit(ctrl.br_sel, flags);
    if (wait_hit) begin
      step_next = step;
    end else if (br_hit) begin
      step_next = ctrl.target;
    end else begin
      step_next = step + ifp_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ifp_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ifp_datapath.sv */
// Datapath of the fragment planner: MTU register, datagram registers,
// chunk arithmetic, checksum and the output register.
// Depends on ifp_pkg.
`default_nettype none

module ifp_datapath (
  input  wire                      clk,
  input  wire                      rst,
  input  wire ifp_pkg::ctrl_word_t ctrl,
  output ifp_pkg::flags_t          flags,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire ifp_pkg::in_word_t   in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output ifp_pkg::out_word_t       out_data,
  input  wire                      cfg_valid,
  input  wire [15:0]               cfg_data
);

  logic [15:0] mtu;
  logic [5:0]  hlen;
  logic [15:0] tlen;
  logic [15:0] ofw;
  logic [15:0] psum;

  logic [15:0] maxd;
  logic [15:0] bytes_left;
  logic [15:0] byte_cursor;
  logic [ifp_pkg::OFF_W-1:0] offset;
  logic [1:0]  status;

  logic [15:0] frag_word;
  logic [15:0] frag_len;
  logic [15:0] frag_start;
  logic [15:0] frag_dlen;
  logic        frag_last;

  logic        in_fire;
  logic        emit_fire;
  logic        out_full;
  logic        special;
  logic [15:0] hlen_ext;
  logic [15:0] link;
  logic [15:0] dlen;
  logic        is_last;
  logic [15:0] csum;

  assign in_ready  = (ctrl.op == ifp_pkg::OP_LOAD);
  assign in_fire   = in_ready && in_valid;
  assign out_full  = out_valid && !out_ready;
  assign emit_fire = (ctrl.op == ifp_pkg::OP_EMIT) && !out_full;

  assign hlen_ext = {10'd0, hlen};
  assign special  = ofw[ifp_pkg::DF_BIT] || (tlen <= hlen_ext);
  assign link     = (mtu < ifp_pkg::MTU_FLOOR) ? ifp_pkg::MTU_FLOOR : mtu;
  assign dlen     = (bytes_left < maxd) ? bytes_left : {maxd[15:3], 3'b000};
  assign is_last  = (dlen >= bytes_left);
  assign csum     = (status == ifp_pkg::STATUS_FRAG) ?
                    ifp_pkg::csum_fold(psum, frag_len, frag_word) : 16'd0;

  assign flags = '{in_valid: in_valid, out_full: out_full, special: special,
                   last: frag_last};

  always_ff @(posedge clk) begin
    if (rst) begin
      mtu <= ifp_pkg::MTU_RESET;
    end else if (cfg_valid) begin
      mtu <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hlen <= in_data.header_len;
      tlen <= in_data.total_len;
      ofw  <= in_data.offset_flags;
      psum <= in_data.partial_sum;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      ifp_pkg::OP_INIT: begin
        maxd        <= link - hlen_ext;
        bytes_left  <= tlen - hlen_ext;
        byte_cursor <= hlen_ext;
        offset      <= ofw[ifp_pkg::OFF_W-1:0];
        if (ofw[ifp_pkg::DF_BIT]) begin
          status <= ifp_pkg::STATUS_DF;
        end else if (special) begin
          status <= ifp_pkg::STATUS_EMPTY;
        end else begin
          status <= ifp_pkg::STATUS_FRAG;
        end
        if (special) begin
          frag_word  <= '0;
          frag_len   <= '0;
          frag_start <= '0;
          frag_dlen  <= '0;
          frag_last  <= 1'b1;
        end
      end
      ifp_pkg::OP_CHUNK: begin
        frag_word   <= {ofw[ifp_pkg::RSV_BIT], 1'b0, (is_last ? ofw[ifp_pkg::MF_BIT] : 1'b1),
                        offset};
        frag_len    <= dlen + hlen_ext;
        frag_start  <= byte_cursor;
        frag_dlen   <= dlen;
        frag_last   <= is_last;
        bytes_left  <= bytes_left - dlen;
        byte_cursor <= byte_cursor + dlen;
        offset      <= offset + dlen[15:3];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data <= '{status: status, frag_offset_flags: frag_word, frag_total_len: frag_len,
                    frag_checksum: csum, data_start: frag_start, data_len: frag_dlen,
                    last: frag_last};
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ifp_pkg::STATUS_FRAG) |-> out_data.last)
    else $error("error word not marked last");
  a_mid_aligned: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last) |->
    (out_data.data_len[2:0] == 3'b000 && out_data.frag_offset_flags[ifp_pkg::MF_BIT]))
    else $error("inner fragment not 8-byte aligned or missing more-fragments");
  a_fits_link: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ifp_pkg::STATUS_FRAG) |->
    (out_data.frag_total_len <= link))
    else $error("fragment longer than the link MTU");
`endif

endmodule

`default_nettype wire

/* rtl/core/ipv4_fragment_planner_core.sv */
// Top level of the IPv4 fragment planner: microcode store, step counter
// and datapath. Depends on ifp_pkg, ifp_ucode_rom, ifp_sequencer, ifp_datapath.
//
//   channel   signals                          direction   word
//   in        in_valid / in_ready / in_data    to block    one datagram description
//   out       out_valid / out_ready / out_data from block  one fragment or error result
//   cfg       cfg_valid / cfg_ready / cfg_data to block    new MTU value
//
// A datagram of N fragments runs the idle and test steps, then the chunk and emit
// steps alternating in the sequencer, one pair per fragment.
// A don't-fragment or empty datagram runs the idle, test and emit steps for its single result.
// Reset is synchronous; it sets the MTU to 1500 and returns to the idle step.
// A stalled output holds the emit step; the next input word is taken while
// the last result of the previous datagram still waits in the output register.
`default_nettype none

module ipv4_fragment_planner_core (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire ifp_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output ifp_pkg::out_word_t      out_data,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire [15:0]              cfg_data
);

  ifp_pkg::step_t      step;
  ifp_pkg::ctrl_word_t ctrl;
  ifp_pkg::flags_t     flags;

  assign cfg_ready = 1'b1;

  ifp_ucode_rom u_rom (
    .step (step),
    .ctrl (ctrl)
  );

  ifp_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .flags (flags),
    .step  (step)
  );

  ifp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .flags     (flags),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

/* bench/ipv4_fragment_planner_core_tb.sv */
// Self-checking bench for ipv4_fragment_planner_core: predicts every fragment word of each
// datagram, checks the block's results in order under random idling and a long output stall.
// Depends on ifp_pkg and the RTL in rtl/core.
module ipv4_fragment_planner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ifp_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int END_CYCLES = 120;
  localparam int LONG_HOLD = 400;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  out_word_t pending_frags[$];
  logic [15:0] link_mtu = MTU_RESET;
  int mismatches = 0;
  int quiet_cycles = 0;
  bit idling_on = 1'b1;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  ipv4_fragment_planner_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] header_checksum(input logic [15:0] a, input logic [15:0] b,
                                                  input logic [15:0] c);
    logic [17:0] acc;
    acc = {2'b00, a} + {2'b00, b} + {2'b00, c};
    acc = {2'b00, acc[15:0]} + {16'd0, acc[17:16]};
    acc = {2'b00, acc[15:0]} + {16'd0, acc[17:16]};
    return ~acc[15:0];
  endfunction

  function automatic void plan_fragments(input in_word_t d);
    logic [15:0] hlen, link, chunk_max, left, cursor, dlen, sent, word, flen;
    logic [12:0] off;
    logic fin;
    out_word_t r;
    int n;
    r = '0;
    r.last = 1'b1;
    hlen = 16'(d.header_len);
    if (d.offset_flags[DF_BIT]) begin
      r.status = STATUS_DF;
      pending_frags.push_back(r);
      return;
    end
    if (d.total_len <= hlen) begin
      r.status = STATUS_EMPTY;
      pending_frags.push_back(r);
      return;
    end
    link = (link_mtu < MTU_FLOOR) ? MTU_FLOOR : link_mtu;
    chunk_max = link - hlen;
    left = d.total_len - hlen;
    cursor = hlen;
    fin = 1'b0;
    n = 0;
    while (!fin && n < 64) begin
      dlen = (left < chunk_max) ? left : (chunk_max & ~16'd7);
      fin = (dlen >= left);
      sent = cursor - hlen;
      off = d.offset_flags[OFF_W-1:0] + sent[15:3];
      word = {d.offset_flags[RSV_BIT], 1'b0, (!fin || d.offset_flags[MF_BIT]), off};
      flen = dlen + hlen;
      r.status = STATUS_FRAG;
      r.frag_offset_flags = word;
      r.frag_total_len = flen;
      r.frag_checksum = header_checksum(d.partial_sum, flen, word);
      r.data_start = cursor;
      r.data_len = dlen;
      r.last = fin;
      pending_frags.push_back(r);
      left = left - dlen;
      cursor = cursor + dlen;
      n++;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch: %s at %0t ns, got %h, expected %h", what, $time, got, want);
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_frags.size() == 0) begin
        report_mismatch("result word with nothing pending", out_data.data_start, 16'd0);
      end else begin
        want = pending_frags.pop_front();
        check_field("status", 16'(out_data.status), 16'(want.status));
        check_field("frag_offset_flags", out_data.frag_offset_flags, want.frag_offset_flags);
        check_field("frag_total_len", out_data.frag_total_len, want.frag_total_len);
        check_field("frag_checksum", out_data.frag_checksum, want.frag_checksum);
        check_field("data_start", out_data.data_start, want.data_start);
        check_field("data_len", out_data.data_len, want.data_len);
        check_field("last", 16'(out_data.last), 16'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      stall_left <= 0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_word_t datagram(input int hlen, input int tlen,
                                        input logic [15:0] ofw, input logic [15:0] psum);
    in_word_t d;
    d.header_len = 6'(hlen);
    d.total_len = 16'(tlen);
    d.offset_flags = ofw;
    d.partial_sum = psum;
    return d;
  endfunction

  function automatic in_word_t random_datagram();
    in_word_t d;
    int kind;
    kind = $urandom_range(0, 19);
    d.header_len = (kind < 16) ? 6'($urandom_range(5, 15) * 4) : 6'($urandom_range(0, 63));
    d.partial_sum = 16'($urandom);
    d.offset_flags = 16'($urandom);
    d.offset_flags[DF_BIT] = (kind == 0);
    if (kind == 1)
      d.total_len = 16'($urandom_range(0, d.header_len));
    else if (kind < 13)
      d.total_len = 16'(d.header_len) + 16'($urandom_range(1, 4000));
    else
      d.total_len = 16'($urandom_range(0, 65535));
    return d;
  endfunction

  task automatic send_datagram(input in_word_t d);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    plan_fragments(d);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_frags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mtu(input logic [15:0] value);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    link_mtu = value;
  endtask

  task automatic test_directed_cases();
    send_datagram(datagram(20, 1000, 16'h4000, 16'h1234));
    send_datagram(datagram(60, 65535, 16'hFFFF, 16'hFFFF));
    send_datagram(datagram(20, 0, 16'h0000, 16'h0000));
    send_datagram(datagram(20, 20, 16'h2000, 16'hABCD));
    send_datagram(datagram(60, 40, 16'h0000, 16'h0000));
    send_datagram(datagram(0, 0, 16'h0000, 16'h0000));
    send_datagram(datagram(20, 21, 16'h0000, 16'h0000));
    send_datagram(datagram(20, 1500, 16'h0000, 16'h0001));
    send_datagram(datagram(22, 1500, 16'h0000, 16'h5555));
    send_datagram(datagram(20, 1501, 16'h2000, 16'h0000));
    send_datagram(datagram(20, 65535, 16'h0000, 16'hFFFF));
    send_datagram(datagram(63, 65535, 16'h9FFF, 16'h8000));
    send_datagram(datagram(21, 3000, 16'h1FF0, 16'h0000));
    send_datagram(datagram(0, 65535, 16'hA000, 16'h7FFF));
    send_datagram(datagram(1, 2, 16'h3FFF, 16'hFFFF));
    send_datagram(datagram(40, 1540, 16'h0001, 16'hFFFE));
  endtask

  task automatic test_mtu_extremes();
    logic [15:0] settings[6];
    settings = '{16'd0, 16'd1279, 16'd1280, 16'd65535, 16'd1281, 16'd9000};
    foreach (settings[i]) begin
      write_mtu(settings[i]);
      send_datagram(datagram(0, 65535, 16'h0000, 16'h1111));
      send_datagram(datagram(20, 65535, 16'h2000, 16'h2222));
      send_datagram(datagram(36, 1316, 16'h8000, 16'h0000));
      send_datagram(random_datagram());
    end
  endtask

  task automatic test_output_stall();
    in_word_t d;
    write_mtu(MTU_FLOOR);
    idling_on = 1'b0;
    hold_request = 1'b1;
    repeat (8) begin
      d = random_datagram();
      d.header_len = 6'd20;
      d.total_len = 16'd65535;
      d.offset_flags[DF_BIT] = 1'b0;
      send_datagram(d);
    end
    drain_block();
    idling_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [15:0] setting;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: setting = 16'($urandom_range(1280, 1580));
        1: setting = 16'($urandom_range(0, 65535));
        2: setting = MTU_RESET;
        3: setting = 16'($urandom_range(0, 1279));
        default: setting = 16'($urandom_range(1280, 16000));
      endcase
      write_mtu(setting);
      idling_on = (phase != 5);
      repeat (45) send_datagram(random_datagram());
    end
  endtask

  task automatic test_final_unthrottled();
    write_mtu(16'($urandom_range(1280, 2000)));
    idling_on = 1'b0;
    repeat (50) send_datagram(random_datagram());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_mtu_extremes();
    test_output_stall();
    test_random_traffic();
    test_final_unthrottled();
    drain_block();
    repeat (END_CYCLES) @(posedge clk);
    if (pending_frags.size() != 0)
      report_mismatch("results never delivered", 16'(pending_frags.size()), 16'd0);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
